// File: rtl/u8je_pkg.sv
// Shared types, codes and character helpers for the UTF-8 to Java escape converter.
package u8je_pkg;

    localparam int MaxResults = 6;
    localparam int RunIdxW    = $clog2(MaxResults);
    localparam int RunCntW    = $clog2(MaxResults + 1);

    // Error codes carried on the result channel
    localparam logic [1:0] ErrNone  = 2'd0;
    localparam logic [1:0] ErrLead  = 2'd1;
    localparam logic [1:0] ErrCont  = 2'd2;
    localparam logic [1:0] ErrRange = 2'd3;

    localparam logic [6:0] ChBslash = 7'h5C;
    localparam logic [6:0] ChZero   = 7'h30;
    localparam logic [6:0] ChLowA   = 7'h61;
    localparam logic [6:0] ChU      = 7'h75;
    localparam logic [6:0] ChB      = 7'h62;
    localparam logic [6:0] ChT      = 7'h74;
    localparam logic [6:0] ChN      = 7'h6E;
    localparam logic [6:0] ChF      = 7'h66;
    localparam logic [6:0] ChR      = 7'h72;
    localparam logic [6:0] ChDquote = 7'h22;
    localparam logic [6:0] ChSquote = 7'h27;

    typedef struct packed {
        logic [6:0] ch;
        logic       text_end;
        logic [1:0] err;
    } t_result;

    function automatic logic [6:0] hex_digit(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10) begin
            r = ChZero + {3'b000, d};
        end else begin
            r = ChLowA + {3'b000, d} - 7'd10;
        end
        return r;
    endfunction

    function automatic logic [6:0] oct_digit(input logic [2:0] d);
        return ChZero + {4'b0000, d};
    endfunction

endpackage

// File: rtl/utf8_to_java_escape_stream.sv
// UTF-8 byte stream to Java escape text converter, one escape character per result.
//
// One UTF-8 byte is taken per transfer and decoded combinationally against the
// sequence state; the whole run of results that the byte causes (zero to six) is
// loaded into a run buffer and drained one result per cycle while i_ready is high.
// A byte that causes at most one result therefore moves at one per cycle while i_ready
// is high; a byte that causes more holds the output until its run drains, and the next
// byte is taken in the cycle in which the last result of the current run transfers.
// A zero byte ends the text and gives an end result; an error gives one error result
// and the bytes up to the next zero are dropped. last_of_run marks each run's last result.
module utf8_to_java_escape_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_text_end,
    output logic [1:0] o_error_code
);

    // sequence state
    logic [15:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic [2:0]  r_remain, n_remain;
    logic        r_skip, n_skip;

    // run buffer
    u8je_pkg::t_result                        r_run [u8je_pkg::MaxResults];
    logic [u8je_pkg::RunIdxW-1:0]             r_pos, n_pos;
    logic [u8je_pkg::RunCntW-1:0]             r_left, n_left;

    u8je_pkg::t_result                        dec_run [u8je_pkg::MaxResults];
    logic [u8je_pkg::RunCntW-1:0]             dec_cnt;
    logic [15:0]                              dec_acc;
    logic                                     dec_ovf;
    logic [2:0]                               dec_remain;
    logic                                     dec_skip;
    logic                                     esc_go;
    logic [15:0]                              esc_v;
    logic [15:0]                              cont_acc;
    logic                                     cont_ovf;
    logic [2:0]                               cont_remain;

    u8je_pkg::t_result                        esc_run [u8je_pkg::MaxResults];
    logic [u8je_pkg::RunCntW-1:0]             esc_cnt;
    logic [6:0]                               esc_short;

    logic in_xfer;
    logic out_xfer;

    assign o_valid  = (r_left != '0);
    assign out_xfer = o_valid && i_ready;
    assign o_ready  = !o_valid || (i_ready && (r_left == u8je_pkg::RunCntW'(1)));
    assign in_xfer  = i_valid && o_ready;

    assign o_out_char    = r_run[r_pos].ch;
    assign o_text_end    = r_run[r_pos].text_end;
    assign o_error_code  = r_run[r_pos].err;
    assign o_last_of_run = (r_left == u8je_pkg::RunCntW'(1));

    // continuation byte: shift in six bits, flag anything pushed above 16 bits
    assign cont_acc    = {r_acc[9:0], i_in_byte[5:0]};
    assign cont_ovf    = r_ovf || (r_acc[15:10] != 6'd0);
    assign cont_remain = r_remain - 3'd1;

    // escape text for a finished code point
    always_comb begin
        for (int i = 0; i < u8je_pkg::MaxResults; i++) begin
            esc_run[i] = '{ch: 7'd0, text_end: 1'b0, err: u8je_pkg::ErrNone};
        end
        esc_short = 7'd0;
        esc_cnt   = '0;
        if (esc_v[15:8] == 8'd0) begin
            unique case (esc_v[7:0])
                8'h08:   esc_short = u8je_pkg::ChB;
                8'h09:   esc_short = u8je_pkg::ChT;
                8'h0A:   esc_short = u8je_pkg::ChN;
                8'h0C:   esc_short = u8je_pkg::ChF;
                8'h0D:   esc_short = u8je_pkg::ChR;
                8'h22:   esc_short = u8je_pkg::ChDquote;
                8'h27:   esc_short = u8je_pkg::ChSquote;
                8'h5C:   esc_short = u8je_pkg::ChBslash;
                default: esc_short = 7'd0;
            endcase
            priority if (esc_short != 7'd0) begin
                esc_run[0].ch = u8je_pkg::ChBslash;
                esc_run[1].ch = esc_short;
                esc_cnt       = u8je_pkg::RunCntW'(2);
            end else if (esc_v[7:0] >= 8'h20 && esc_v[7:0] <= 8'h7E) begin
                esc_run[0].ch = esc_v[6:0];
                esc_cnt       = u8je_pkg::RunCntW'(1);
            end else begin
                esc_run[0].ch = u8je_pkg::ChBslash;
                esc_run[1].ch = u8je_pkg::oct_digit({1'b0, esc_v[7:6]});
                esc_run[2].ch = u8je_pkg::oct_digit(esc_v[5:3]);
                esc_run[3].ch = u8je_pkg::oct_digit(esc_v[2:0]);
                esc_cnt       = u8je_pkg::RunCntW'(4);
            end
        end else begin
            esc_run[0].ch = u8je_pkg::ChBslash;
            esc_run[1].ch = u8je_pkg::ChU;
            esc_run[2].ch = u8je_pkg::hex_digit(esc_v[15:12]);
            esc_run[3].ch = u8je_pkg::hex_digit(esc_v[11:8]);
            esc_run[4].ch = u8je_pkg::hex_digit(esc_v[7:4]);
            esc_run[5].ch = u8je_pkg::hex_digit(esc_v[3:0]);
            esc_cnt       = u8je_pkg::RunCntW'(6);
        end
    end

    // byte decode against the sequence state
    always_comb begin
        for (int i = 0; i < u8je_pkg::MaxResults; i++) begin
            dec_run[i] = '{ch: 7'd0, text_end: 1'b0, err: u8je_pkg::ErrNone};
        end
        dec_cnt    = '0;
        dec_acc    = r_acc;
        dec_ovf    = r_ovf;
        dec_remain = r_remain;
        dec_skip   = r_skip;
        esc_go     = 1'b0;
        esc_v      = 16'd0;
        if (r_skip) begin
            if (i_in_byte == 8'd0) begin
                dec_skip            = 1'b0;
                dec_acc             = 16'd0;
                dec_ovf             = 1'b0;
                dec_remain          = 3'd0;
                dec_run[0].text_end = 1'b1;
                dec_cnt             = u8je_pkg::RunCntW'(1);
            end
        end else if (r_remain == 3'd0) begin
            priority if (i_in_byte == 8'd0) begin
                dec_run[0].text_end = 1'b1;
                dec_cnt             = u8je_pkg::RunCntW'(1);
            end else if (!i_in_byte[7]) begin
                esc_go = 1'b1;
                esc_v  = {8'd0, i_in_byte};
            end else if (i_in_byte < 8'hC0 || i_in_byte >= 8'hFE) begin
                dec_skip       = 1'b1;
                dec_acc        = 16'd0;
                dec_ovf        = 1'b0;
                dec_run[0].err = u8je_pkg::ErrLead;
                dec_cnt        = u8je_pkg::RunCntW'(1);
            end else if (i_in_byte < 8'hE0) begin
                dec_acc    = {11'd0, i_in_byte[4:0]};
                dec_ovf    = 1'b0;
                dec_remain = 3'd1;
            end else if (i_in_byte < 8'hF0) begin
                dec_acc    = {12'd0, i_in_byte[3:0]};
                dec_ovf    = 1'b0;
                dec_remain = 3'd2;
            end else if (i_in_byte < 8'hF8) begin
                dec_acc    = {13'd0, i_in_byte[2:0]};
                dec_ovf    = 1'b0;
                dec_remain = 3'd3;
            end else if (i_in_byte < 8'hFC) begin
                dec_acc    = {14'd0, i_in_byte[1:0]};
                dec_ovf    = 1'b0;
                dec_remain = 3'd4;
            end else begin
                dec_acc    = {15'd0, i_in_byte[0]};
                dec_ovf    = 1'b0;
                dec_remain = 3'd5;
            end
        end else begin
            priority if (i_in_byte == 8'd0) begin
                // terminator inside a sequence: bad continuation, then end
                dec_acc             = 16'd0;
                dec_ovf             = 1'b0;
                dec_remain          = 3'd0;
                dec_run[0].err      = u8je_pkg::ErrCont;
                dec_run[1].text_end = 1'b1;
                dec_cnt             = u8je_pkg::RunCntW'(2);
            end else if (i_in_byte[7:6] != 2'b10) begin
                dec_skip       = 1'b1;
                dec_acc        = 16'd0;
                dec_ovf        = 1'b0;
                dec_remain     = 3'd0;
                dec_run[0].err = u8je_pkg::ErrCont;
                dec_cnt        = u8je_pkg::RunCntW'(1);
            end else if (cont_remain != 3'd0) begin
                dec_acc    = cont_acc;
                dec_ovf    = cont_ovf;
                dec_remain = cont_remain;
            end else if (cont_ovf) begin
                dec_skip       = 1'b1;
                dec_acc        = 16'd0;
                dec_ovf        = 1'b0;
                dec_remain     = 3'd0;
                dec_run[0].err = u8je_pkg::ErrRange;
                dec_cnt        = u8je_pkg::RunCntW'(1);
            end else begin
                dec_acc    = 16'd0;
                dec_ovf    = 1'b0;
                dec_remain = 3'd0;
                esc_go     = 1'b1;
                esc_v      = cont_acc;
            end
        end
    end

    always_comb begin
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_remain = r_remain;
        n_skip   = r_skip;
        n_pos    = r_pos;
        n_left   = r_left;
        if (out_xfer) begin
            n_pos  = r_pos + u8je_pkg::RunIdxW'(1);
            n_left = r_left - u8je_pkg::RunCntW'(1);
        end
        if (in_xfer) begin
            n_acc    = dec_acc;
            n_ovf    = dec_ovf;
            n_remain = dec_remain;
            n_skip   = dec_skip;
            n_pos    = '0;
            n_left   = esc_go ? esc_cnt : dec_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 16'd0;
            r_ovf    <= 1'b0;
            r_remain <= 3'd0;
            r_skip   <= 1'b0;
            r_pos    <= '0;
            r_left   <= '0;
        end else begin
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_remain <= n_remain;
            r_skip   <= n_skip;
            r_pos    <= n_pos;
            r_left   <= n_left;
        end
    end

    // load the run of results for the byte just taken
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < u8je_pkg::MaxResults; i++) begin
                r_run[i] <= esc_go ? esc_run[i] : dec_run[i];
            end
        end
    end

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= u8je_pkg::RunCntW'(u8je_pkg::MaxResults))
        else $error("run buffer count above maximum");

    a_skip_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_remain == 3'd0))
        else $error("skipping while a sequence is open");

    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && o_valid) |-> (i_ready && o_last_of_run))
        else $error("byte taken while run still pending");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_end) |-> o_last_of_run)
        else $error("end result not last of its run");

    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != u8je_pkg::ErrNone) |-> (o_out_char == 7'd0 && !o_text_end))
        else $error("error result carries a character");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_left == $past(r_left)))
        else $error("run count moved without a transfer");

endmodule
